[src/overlapping_seed_suppressor_top_defines.svh]
// Assertion macros for the file that carries concurrent checks.
// Each macro expects clk and rst_n in scope.
`ifndef OVERLAPPING_SEED_SUPPRESSOR_TOP_DEFINES_SVH
`define OVERLAPPING_SEED_SUPPRESSOR_TOP_DEFINES_SVH

`define OSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define OSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/oss_pkg.sv]
`default_nettype none
package oss_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned SEED_W  = 3 * FIELD_W;
  localparam int unsigned CNT_W   = 31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_I_RD,
    ST_I_LD,
    ST_J_RD,
    ST_J_CMP,
    ST_J_OV,
    ST_C_RD,
    ST_C_CHK,
    ST_E_RD,
    ST_E_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic list_close;
    logic rd_i;
    logic i_latch;
    logic i_inc;
    logic rd_j;
    logic j_latch;
    logic j_inc;
    logic kill_i;
    logic kill_j;
    logic rd_k;
    logic cnt_chk;
    logic cnt_done;
    logic emit;
    logic emit_end;
  } cmd_t;

  typedef struct packed {
    logic merge_on;
    logic i_done;
    logic j_done;
    logic k_done;
    logic rd_dead;
    logic scan_go;
    logic overlap;
    logic kill_j_sel;
  } status_t;

endpackage
`default_nettype wire

[src/oss_ram.sv]
`default_nettype none
module oss_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

[src/oss_ctrl.sv]
`default_nettype none
module oss_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            last_seed,
  input  wire oss_pkg::status_t st,
  output oss_pkg::cmd_t        cmd,
  output logic                 busy
);

  oss_pkg::state_t state_r;
  oss_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oss_pkg::ST_IDLE: begin
        if (start && last_seed) begin
          state_nxt = st.merge_on ? oss_pkg::ST_I_RD : oss_pkg::ST_E_RD;
        end
      end
      oss_pkg::ST_I_RD: begin
        state_nxt = st.i_done ? oss_pkg::ST_C_RD : oss_pkg::ST_I_LD;
      end
      oss_pkg::ST_I_LD: begin
        state_nxt = st.rd_dead ? oss_pkg::ST_I_RD : oss_pkg::ST_J_RD;
      end
      oss_pkg::ST_J_RD: begin
        state_nxt = st.j_done ? oss_pkg::ST_I_RD : oss_pkg::ST_J_CMP;
      end
      oss_pkg::ST_J_CMP: begin
        state_nxt = st.scan_go ? oss_pkg::ST_J_OV : oss_pkg::ST_I_RD;
      end
      oss_pkg::ST_J_OV: begin
        if (st.overlap && !st.kill_j_sel) begin
          state_nxt = oss_pkg::ST_I_RD;
        end else begin
          state_nxt = oss_pkg::ST_J_RD;
        end
      end
      oss_pkg::ST_C_RD: begin
        state_nxt = st.k_done ? oss_pkg::ST_E_RD : oss_pkg::ST_C_CHK;
      end
      oss_pkg::ST_C_CHK: begin
        state_nxt = oss_pkg::ST_C_RD;
      end
      oss_pkg::ST_E_RD: begin
        state_nxt = st.k_done ? oss_pkg::ST_IDLE : oss_pkg::ST_E_OUT;
      end
      oss_pkg::ST_E_OUT: begin
        state_nxt = oss_pkg::ST_E_RD;
      end
      default: begin
        state_nxt = oss_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      oss_pkg::ST_IDLE: begin
        busy           = 1'b0;
        cmd.load       = start;
        cmd.list_close = start && last_seed;
      end
      oss_pkg::ST_I_RD: begin
        cmd.rd_i = !st.i_done;
      end
      oss_pkg::ST_I_LD: begin
        cmd.i_latch = 1'b1;
        cmd.i_inc   = st.rd_dead;
      end
      oss_pkg::ST_J_RD: begin
        cmd.rd_j  = !st.j_done;
        cmd.i_inc = st.j_done;
      end
      oss_pkg::ST_J_CMP: begin
        cmd.j_latch = 1'b1;
        cmd.i_inc   = !st.scan_go;
      end
      oss_pkg::ST_J_OV: begin
        if (st.overlap && !st.kill_j_sel) begin
          cmd.kill_i = 1'b1;
          cmd.i_inc  = 1'b1;
        end else begin
          cmd.kill_j = st.overlap;
          cmd.j_inc  = 1'b1;
        end
      end
      oss_pkg::ST_C_RD: begin
        cmd.rd_k     = !st.k_done;
        cmd.cnt_done = st.k_done;
      end
      oss_pkg::ST_C_CHK: begin
        cmd.cnt_chk = 1'b1;
      end
      oss_pkg::ST_E_RD: begin
        cmd.rd_k     = !st.k_done;
        cmd.emit_end = st.k_done;
      end
      oss_pkg::ST_E_OUT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/oss_dp.sv]
`default_nettype none
module oss_dp #(
  parameter int unsigned MAX_SEEDS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire oss_pkg::cmd_t      cmd,
  output oss_pkg::status_t        st,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic signed [31:0] in_first_start,
  input  wire logic signed [31:0] in_second_start,
  input  wire logic signed [31:0] in_seed_length,
  output logic                    out_valid,
  output logic signed [31:0]      out_kept_first_start,
  output logic signed [31:0]      out_kept_second_start,
  output logic signed [31:0]      out_kept_length,
  output logic                    out_seed_valid,
  output logic [30:0]             out_removed_total,
  output logic                    out_last_result
);

  localparam int unsigned AW = $clog2(MAX_SEEDS);
  localparam int unsigned CW = $clog2(MAX_SEEDS + 1);
  localparam int unsigned FW = oss_pkg::FIELD_W;
  localparam int unsigned SW = oss_pkg::SEED_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEEDS);
  localparam logic [oss_pkg::CNT_W-1:0] CNT_MAX = '1;

  logic [CW-1:0] loaded_r, loaded_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic [AW-1:0] last_idx_r, last_idx_nxt;
  logic          emitted_r, emitted_nxt;
  logic          merge_en_r, merge_en_nxt;
  logic [oss_pkg::CNT_W-1:0] removed_r, removed_nxt;

  logic signed [FW:0]   fend_i_r, fend_i_nxt;
  logic signed [FW:0]   p2i_r, p2i_nxt;
  logic signed [FW:0]   endi_r, endi_nxt;
  logic signed [FW-1:0] leni_r, leni_nxt;
  logic signed [FW:0]   p2j_r, p2j_nxt;
  logic signed [FW:0]   endj_r, endj_nxt;
  logic signed [FW-1:0] lenj_r, lenj_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [FW-1:0] out_fs_r, out_fs_nxt;
  logic signed [FW-1:0] out_ss_r, out_ss_nxt;
  logic signed [FW-1:0] out_len_r, out_len_nxt;
  logic                 out_sv_r, out_sv_nxt;
  logic [oss_pkg::CNT_W-1:0] out_rem_r, out_rem_nxt;
  logic                 out_last_r, out_last_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;

  logic signed [FW-1:0] rd_fs, rd_ss, rd_len;
  logic                 load_ok;
  logic [CW-1:0]        loaded_inc;
  logic [oss_pkg::CNT_W:0] rem_sum;
  logic                 k_is_last;

  assign rd_fs  = ram_rdata[SW-1 -: FW];
  assign rd_ss  = ram_rdata[2*FW-1 -: FW];
  assign rd_len = ram_rdata[FW-1:0];

  assign load_ok    = loaded_r < MAX_CNT;
  assign loaded_inc = load_ok ? loaded_r + CW'(1) : loaded_r;

  assign rem_sum = {1'b0, removed_r} + (oss_pkg::CNT_W + 1)'(n_r - kept_r);

  assign k_is_last = merge_en_r ? (k_r[AW-1:0] == last_idx_r) : (k_r == n_r - CW'(1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = loaded_r[AW-1:0];
    ram_wdata = {in_first_start, in_second_start, in_seed_length};
    if (cmd.load) begin
      ram_we = load_ok;
    end else if (cmd.kill_j) begin
      ram_we    = 1'b1;
      ram_waddr = j_r[AW-1:0];
      ram_wdata = '1;
    end else if (cmd.kill_i) begin
      ram_we    = 1'b1;
      ram_waddr = i_r[AW-1:0];
      ram_wdata = '1;
    end
  end

  always_comb begin
    ram_re    = cmd.rd_i || cmd.rd_j || cmd.rd_k;
    ram_raddr = k_r[AW-1:0];
    if (cmd.rd_i) begin
      ram_raddr = i_r[AW-1:0];
    end else if (cmd.rd_j) begin
      ram_raddr = j_r[AW-1:0];
    end
  end

  oss_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_SEEDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    st.merge_on   = merge_en_r;
    st.i_done     = i_r >= n_r;
    st.j_done     = j_r >= n_r;
    st.k_done     = k_r >= n_r;
    st.rd_dead    = rd_fs == '1;
    st.scan_go    = (rd_fs != '1) && ((FW+1)'(rd_fs) < fend_i_r);
    st.overlap    = ((p2j_r >= p2i_r) && (p2j_r < endi_r)) ||
                    ((endj_r >= p2i_r) && (endj_r < endi_r));
    st.kill_j_sel = lenj_r <= leni_r;
  end

  always_comb begin
    loaded_nxt   = loaded_r;
    n_nxt        = n_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    kept_nxt     = kept_r;
    last_idx_nxt = last_idx_r;
    emitted_nxt  = emitted_r;
    merge_en_nxt = cfg_we ? cfg_wdata : merge_en_r;
    removed_nxt  = removed_r;
    fend_i_nxt   = fend_i_r;
    p2i_nxt      = p2i_r;
    endi_nxt     = endi_r;
    leni_nxt     = leni_r;
    p2j_nxt      = p2j_r;
    endj_nxt     = endj_r;
    lenj_nxt     = lenj_r;
    out_valid_nxt = 1'b0;
    out_fs_nxt   = out_fs_r;
    out_ss_nxt   = out_ss_r;
    out_len_nxt  = out_len_r;
    out_sv_nxt   = out_sv_r;
    out_rem_nxt  = out_rem_r;
    out_last_nxt = out_last_r;

    if (cmd.load) begin
      loaded_nxt = loaded_inc;
    end
    if (cmd.list_close) begin
      loaded_nxt  = '0;
      n_nxt       = loaded_inc;
      i_nxt       = '0;
      k_nxt       = '0;
      kept_nxt    = '0;
      emitted_nxt = 1'b0;
    end
    if (cmd.i_latch) begin
      fend_i_nxt = (FW+1)'(rd_fs) + (FW+1)'(rd_len);
      p2i_nxt    = (FW+1)'(rd_ss);
      endi_nxt   = (FW+1)'(rd_ss) + (FW+1)'(rd_len);
      leni_nxt   = rd_len;
      j_nxt      = i_r + CW'(1);
    end
    if (cmd.i_inc) begin
      i_nxt = i_r + CW'(1);
    end
    if (cmd.j_latch) begin
      p2j_nxt  = (FW+1)'(rd_ss);
      endj_nxt = (FW+1)'(rd_ss) + (FW+1)'(rd_len);
      lenj_nxt = rd_len;
    end
    if (cmd.j_inc) begin
      j_nxt = j_r + CW'(1);
    end
    if (cmd.cnt_chk) begin
      if (rd_fs != '1) begin
        kept_nxt     = kept_r + CW'(1);
        last_idx_nxt = k_r[AW-1:0];
      end
      k_nxt = k_r + CW'(1);
    end
    if (cmd.cnt_done) begin
      k_nxt       = '0;
      removed_nxt = rem_sum[oss_pkg::CNT_W] ? CNT_MAX : rem_sum[oss_pkg::CNT_W-1:0];
    end
    if (cmd.emit) begin
      if (!merge_en_r || (rd_fs != '1)) begin
        out_valid_nxt = 1'b1;
        out_fs_nxt    = rd_fs;
        out_ss_nxt    = rd_ss;
        out_len_nxt   = rd_len;
        out_sv_nxt    = 1'b1;
        out_rem_nxt   = removed_r;
        out_last_nxt  = k_is_last;
        emitted_nxt   = 1'b1;
      end
      k_nxt = k_r + CW'(1);
    end
    if (cmd.emit_end && !emitted_r) begin
      out_valid_nxt = 1'b1;
      out_fs_nxt    = '0;
      out_ss_nxt    = '0;
      out_len_nxt   = '0;
      out_sv_nxt    = 1'b0;
      out_rem_nxt   = removed_r;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= '0;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      kept_r      <= '0;
      emitted_r   <= 1'b0;
      merge_en_r  <= 1'b1;
      removed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      loaded_r    <= loaded_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      kept_r      <= kept_nxt;
      emitted_r   <= emitted_nxt;
      merge_en_r  <= merge_en_nxt;
      removed_r   <= removed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_idx_r <= last_idx_nxt;
    fend_i_r   <= fend_i_nxt;
    p2i_r      <= p2i_nxt;
    endi_r     <= endi_nxt;
    leni_r     <= leni_nxt;
    p2j_r      <= p2j_nxt;
    endj_r     <= endj_nxt;
    lenj_r     <= lenj_nxt;
    out_fs_r   <= out_fs_nxt;
    out_ss_r   <= out_ss_nxt;
    out_len_r  <= out_len_nxt;
    out_sv_r   <= out_sv_nxt;
    out_rem_r  <= out_rem_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_kept_first_start  = out_fs_r;
  assign out_kept_second_start = out_ss_r;
  assign out_kept_length       = out_len_r;
  assign out_seed_valid        = out_sv_r;
  assign out_removed_total     = out_rem_r;
  assign out_last_result       = out_last_r;

endmodule
`default_nettype wire

[src/overlapping_seed_suppressor_top.sv]
// Channel    Transfer when           Fields
// input      start && !busy          in_first_start, in_second_start, in_seed_length,
//                                    in_last_seed
// result     out_valid (one cycle)   out_kept_first_start, out_kept_second_start,
//                                    out_kept_length, out_seed_valid,
//                                    out_removed_total, out_last_result
// config     cfg_we                  cfg_wdata (merge enable)
//
// A seed that does not close the list is stored if the RAM has room; busy stays low.
// The closing seed starts the merge (straight to emit if merge is off): one RAM read
// port serves all passes, so an inner comparison steps J_RD, J_CMP, J_OV, an outer
// step I_RD, I_LD, then each stored seed gets a count step C_RD, C_CHK and an emit
// step E_RD, E_OUT. Synchronous active-low reset clears the counters and sets merge
// enable; the seed RAM is not cleared. The receiver cannot stall the result strobe.
`default_nettype none
module overlapping_seed_suppressor_top #(
  parameter int unsigned MAX_SEEDS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_first_start,
  input  wire logic signed [31:0] in_second_start,
  input  wire logic signed [31:0] in_seed_length,
  input  wire logic               in_last_seed,
  output logic                    out_valid,
  output logic signed [31:0]      out_kept_first_start,
  output logic signed [31:0]      out_kept_second_start,
  output logic signed [31:0]      out_kept_length,
  output logic                    out_seed_valid,
  output logic [30:0]             out_removed_total,
  output logic                    out_last_result,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata
);

  oss_pkg::cmd_t    cmd;
  oss_pkg::status_t st;

  oss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .last_seed(in_last_seed),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  oss_dp #(
    .MAX_SEEDS(MAX_SEEDS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_first_start       (in_first_start),
    .in_second_start      (in_second_start),
    .in_seed_length       (in_seed_length),
    .out_valid            (out_valid),
    .out_kept_first_start (out_kept_first_start),
    .out_kept_second_start(out_kept_second_start),
    .out_kept_length      (out_kept_length),
    .out_seed_valid       (out_seed_valid),
    .out_removed_total    (out_removed_total),
    .out_last_result      (out_last_result)
  );

`include "overlapping_seed_suppressor_top_defines.svh"

  `OSS_ASSERT_SAME(a_empty_is_last, out_valid && !out_seed_valid, out_last_result, "empty result not last")
  `OSS_ASSERT_SAME(a_mid_result_busy, out_valid && !out_last_result, busy, "result outside list")
  `OSS_ASSERT_NEXT(a_strobe_gap, out_valid, !out_valid, "results back to back")
  `OSS_ASSERT_NEXT(a_load_stays_idle, start && !busy && !in_last_seed, !busy, "load left idle")

endmodule
`default_nettype wire

[dv/tb_overlapping_seed_suppressor_top.sv]
`default_nettype none
module tb_overlapping_seed_suppressor_top;

  localparam int MAX_SEEDS = 64;
  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam longint CNT_MAX = 64'h7fff_ffff;

  typedef struct packed {
    logic [oss_pkg::FIELD_W-1:0] fs;
    logic [oss_pkg::FIELD_W-1:0] ss;
    logic [oss_pkg::FIELD_W-1:0] len;
    logic                        close;
  } seed_item_t;

  typedef struct packed {
    logic [oss_pkg::FIELD_W-1:0] fs;
    logic [oss_pkg::FIELD_W-1:0] ss;
    logic [oss_pkg::FIELD_W-1:0] len;
    logic                        has_seed;
    logic [oss_pkg::CNT_W-1:0]   total;
    logic                        tail;
  } kept_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [31:0] in_first_start;
  logic signed [31:0] in_second_start;
  logic signed [31:0] in_seed_length;
  logic in_last_seed;
  logic out_valid;
  logic signed [31:0] out_kept_first_start;
  logic signed [31:0] out_kept_second_start;
  logic signed [31:0] out_kept_length;
  logic out_seed_valid;
  logic [30:0] out_removed_total;
  logic out_last_result;
  logic cfg_we;
  logic cfg_wdata;

  seed_item_t pending_seeds[$];
  kept_t expected_survivors[$];
  int seeds_queued = 0;
  int mismatches = 0;
  bit no_gaps = 1'b0;
  bit took = 1'b0;

  logic signed [31:0] held_first[MAX_SEEDS];
  logic signed [31:0] held_second[MAX_SEEDS];
  logic signed [31:0] held_len[MAX_SEEDS];
  int held_count;
  longint removed_sum;
  bit merge_on;

  overlapping_seed_suppressor_top #(.MAX_SEEDS(MAX_SEEDS)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_first_start(in_first_start),
    .in_second_start(in_second_start),
    .in_seed_length(in_seed_length),
    .in_last_seed(in_last_seed),
    .out_valid(out_valid),
    .out_kept_first_start(out_kept_first_start),
    .out_kept_second_start(out_kept_second_start),
    .out_kept_length(out_kept_length),
    .out_seed_valid(out_seed_valid),
    .out_removed_total(out_removed_total),
    .out_last_result(out_last_result),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic log_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic absorb_seed(input seed_item_t sd);
    int n, lastk, j, k, emitted;
    longint gone, a0, a1, b0, b1;
    kept_t r;
    if (held_count < MAX_SEEDS) begin
      held_first[held_count] = sd.fs;
      held_second[held_count] = sd.ss;
      held_len[held_count] = sd.len;
      held_count++;
    end
    if (sd.close) begin
      n = held_count;
      held_count = 0;
      lastk = -1;
      emitted = 0;
      if (merge_on) begin
        for (int i = 0; i < n; i++) begin
          j = i + 1;
          while (held_first[i] != -1 && j < n && held_first[j] != -1 &&
                 longint'(held_first[j]) < longint'(held_first[i]) + longint'(held_len[i])) begin
            a0 = held_second[i];
            a1 = a0 + held_len[i];
            b0 = held_second[j];
            b1 = b0 + held_len[j];
            if ((b0 >= a0 && b0 < a1) || (b1 >= a0 && b1 < a1)) begin
              k = (held_len[j] <= held_len[i]) ? j : i;
              held_first[k] = -1;
              held_second[k] = -1;
              held_len[k] = -1;
            end
            j++;
          end
        end
        gone = n;
        for (int i = 0; i < n; i++) begin
          if (held_first[i] != -1) begin
            lastk = i;
            gone--;
          end
        end
        if (gone > CNT_MAX - removed_sum) removed_sum = CNT_MAX;
        else removed_sum += gone;
        for (int i = 0; i < n; i++) begin
          if (held_first[i] != -1) begin
            r.fs = held_first[i];
            r.ss = held_second[i];
            r.len = held_len[i];
            r.has_seed = 1'b1;
            r.total = removed_sum[oss_pkg::CNT_W-1:0];
            r.tail = (i == lastk);
            expected_survivors.push_back(r);
            emitted++;
          end
        end
      end else begin
        for (int i = 0; i < n; i++) begin
          r.fs = held_first[i];
          r.ss = held_second[i];
          r.len = held_len[i];
          r.has_seed = 1'b1;
          r.total = removed_sum[oss_pkg::CNT_W-1:0];
          r.tail = (i == n - 1);
          expected_survivors.push_back(r);
          emitted++;
        end
      end
      if (emitted == 0) begin
        r = '0;
        r.total = removed_sum[oss_pkg::CNT_W-1:0];
        r.tail = 1'b1;
        expected_survivors.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    kept_t want;
    if (!rst_n) begin
      took = 1'b0;
      held_count = 0;
      removed_sum = 0;
      merge_on = 1'b1;
    end else begin
      took = start && !busy;
      if (cfg_we) merge_on = cfg_wdata;
      if (took) absorb_seed({in_first_start, in_second_start, in_seed_length, in_last_seed});
      if (out_valid) begin
        if (expected_survivors.size() == 0) begin
          log_mismatch("result transfer with no survivor expected");
        end else begin
          want = expected_survivors.pop_front();
          if (out_kept_first_start !== want.fs)
            log_mismatch($sformatf("kept_first_start %0d, expected %0d",
                                   out_kept_first_start, $signed(want.fs)));
          if (out_kept_second_start !== want.ss)
            log_mismatch($sformatf("kept_second_start %0d, expected %0d",
                                   out_kept_second_start, $signed(want.ss)));
          if (out_kept_length !== want.len)
            log_mismatch($sformatf("kept_length %0d, expected %0d",
                                   out_kept_length, $signed(want.len)));
          if (out_seed_valid !== want.has_seed)
            log_mismatch($sformatf("seed_valid %0b, expected %0b", out_seed_valid,
                                   want.has_seed));
          if (out_removed_total !== want.total)
            log_mismatch($sformatf("removed_total %0d, expected %0d", out_removed_total,
                                   want.total));
          if (out_last_result !== want.tail)
            log_mismatch($sformatf("last_result %0b, expected %0b", out_last_result,
                                   want.tail));
        end
      end
    end
  end

  always @(negedge clk) begin : drive_seeds
    seed_item_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (pending_seeds.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 36)) begin
        nxt = pending_seeds.pop_front();
        in_first_start <= nxt.fs;
        in_second_start <= nxt.ss;
        in_seed_length <= nxt.len;
        in_last_seed <= nxt.close;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_seed(input logic signed [31:0] f, input logic signed [31:0] s,
                            input logic signed [31:0] l, input logic close);
    seed_item_t sd;
    sd.fs = f;
    sd.ss = s;
    sd.len = l;
    sd.close = close;
    pending_seeds.push_back(sd);
    seeds_queued++;
  endtask

  function automatic logic signed [31:0] pick_field();
    case ($urandom_range(0, 5))
      0: return -1;
      1: return 0;
      2: return MAXV;
      3: return $urandom_range(0, 40);
      default: return $urandom & 32'h7fff_ffff;
    endcase
  endfunction

  // Clustered lists keep first starts ascending and second starts close together,
  // so most seeds fall inside a neighbor and get compared.
  task automatic queue_list(input int count, input bit noisy);
    logic signed [31:0] pos1, pos2, f, s, l;
    pos1 = ($urandom_range(0, 5) == 0) ? 32'sh7fff_f000 : $urandom_range(0, 100000);
    pos2 = ($urandom_range(0, 5) == 0) ? 32'sh7fff_f000 : $urandom_range(0, 100000);
    for (int k = 0; k < count; k++) begin
      if (noisy) begin
        f = pick_field();
        s = pick_field();
        l = pick_field();
      end else begin
        pos1 = pos1 + $urandom_range(0, 6);
        f = ($urandom_range(0, 9) == 0) ? -1 : pos1;
        s = pos2 + $urandom_range(0, 24);
        case ($urandom_range(0, 9))
          0: l = pick_field();
          1: l = 0;
          default: l = $urandom_range(1, 14);
        endcase
        if (f == -1 && $urandom_range(0, 1) == 1) begin
          s = -1;
          l = -1;
        end
      end
      queue_seed(f, s, l, k == count - 1);
    end
  endtask

  task automatic settle();
    while (pending_seeds.size() != 0 || start || expected_survivors.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_enable(input bit v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #10_000_000;
    $display("overlapping_seed_suppressor_top regression: fail");
    $finish;
  end

  initial begin
    int goal;
    rst_n = 1'b0;
    start = 1'b0;
    in_first_start = '0;
    in_second_start = '0;
    in_seed_length = '0;
    in_last_seed = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_seed(0, 0, 0, 1'b1);
    queue_seed(-1, 7, 9, 1'b1);
    queue_seed(10, 100, 5, 1'b0);
    queue_seed(12, 102, 5, 1'b1);
    queue_seed(10, 100, 3, 1'b0);
    queue_seed(11, 101, 8, 1'b1);
    queue_seed(10, 100, 5, 1'b0);
    queue_seed(12, 96, 5, 1'b1);
    queue_seed(10, 100, 5, 1'b0);
    queue_seed(15, 100, 5, 1'b1);
    queue_seed(MAXV - 1, MAXV - 7, MAXV, 1'b0);
    queue_seed(MAXV, MAXV, MAXV, 1'b1);
    queue_seed(0, 0, 10, 1'b0);
    queue_seed(-1, -1, -1, 1'b0);
    queue_seed(2, 0, 3, 1'b1);
    queue_seed(5, 5, -1, 1'b0);
    queue_seed(5, 5, -1, 1'b1);
    settle();
    write_enable(1'b0);
    queue_seed(-1, -1, -1, 1'b0);
    queue_seed(3, 3, 3, 1'b1);
    queue_seed(-1, -1, -1, 1'b1);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      write_enable(ph % 2 == 0);
      no_gaps = (ph == 2);
      goal = seeds_queued + 110;
      if (ph < 2) queue_list(ph == 0 ? 70 : 66, 1'b0);
      else queue_list(MAX_SEEDS, 1'b0);
      while (seeds_queued < goal)
        queue_list(($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10),
                   $urandom_range(0, 4) == 0);
      settle();
    end

    if (mismatches == 0) begin
      $display("overlapping_seed_suppressor_top regression: pass");
    end else begin
      $display("overlapping_seed_suppressor_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
